### sv/pressure_temperature_compensation_unit_macros.svh
// Assertion macros for the pressure/temperature compensation unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH

// cond in this cycle implies chk in the next one
`define PTC_ASSERT_NEXT(lbl, cond, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (chk)) \
		else $error(msg);

// cond implies chk in the same cycle
`define PTC_ASSERT_SAME(lbl, cond, chk, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (chk)) \
		else $error(msg);

`endif

### sv/ptc_pkg.sv
// Package for the pressure/temperature compensation unit: coefficient type,
// calibration register indexes, formula constants and the unpack function. No dependencies.
package ptc_pkg;

	typedef struct packed {
		logic [12:0] c1;
		logic [12:0] c2;
		logic [8:0]  c3;
		logic [8:0]  c4;
		logic [11:0] c5;
		logic [7:0]  c6;
	} coef_t;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CAL_ONE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TWO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_THREE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_FOUR  = 2'd3;

	localparam int C5_BIAS    = 200;
	localparam int UT1_BASE   = 15136;
	localparam int C6_BIAS    = 262;
	localparam int TEMP_BASE  = 2000;
	localparam int TEMP_SHIFT = 9;     // / 512
	localparam int CAL_BIAS   = 2000;
	localparam int OFF_BASE   = 10381;
	localparam int C4_BIAS    = 243;
	localparam int OFF_SHIFT  = 12;    // / 4096
	localparam int SENS_BASE  = 10179;
	localparam int C3_BIAS    = 222;
	localparam int SENS_SHIFT = 11;    // / 2048
	localparam int X_SHIFT    = 12;    // / 4096
	localparam int P_SCALE    = 1365;
	localparam int P_SHIFT    = 9;     // / 512
	localparam int C2_MASK    = 'h1FFF;

	function automatic coef_t unpack_coef(input logic [15:0] w1, input logic [15:0] w2,
			input logic [15:0] w3, input logic [15:0] w4);
		coef_t c;
		c.c1 = {w4[15], w3[11:0]};
		c.c2 = w4[12:0] & 13'(C2_MASK);
		c.c3 = {w4[13], w1[15:8]};
		c.c4 = {w4[14], w2[15:8]};
		c.c5 = {w3[15:12], w1[7:0]};
		c.c6 = w2[7:0];
		return c;
	endfunction

endpackage

### sv/pressure_temperature_compensation_unit.sv
// Top level of the pressure/temperature compensation unit: calibration registers
// and an eight-stage compensation pipeline. Depends on ptc_pkg and the macro header.
//
// Usage:
//   Input channel: pressure_raw (D1) and temperature_raw (D2) with in_valid/in_stall.
//   An item is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: temperature_centi and pressure_centi with out_valid/out_stall.
//   Calibration: cfg_we, cfg_index (0..3 = calibration words one..four), cfg_data.
//   Write the four words while the pipeline is empty; they feed stages 1..3 directly.
// Throughput: one item per cycle while no stalled result holds the output. Pipeline:
//   eight register stages (D2 offset, three multipliers, three rounding/offset adds,
//   difference, pressure product, rounding, scale, rounding); the outputs are driven
//   straight from the stage-eight registers.
// Stall: the pipeline advances as one; while a valid result sits at the output and
//   out_stall is high, every stage holds and in_stall is raised. Nothing is dropped.
// Reset: arst_n clears all valid bits and the calibration words to zero; with zero
//   words the formulas still apply.
`include "pressure_temperature_compensation_unit_macros.svh"

module pressure_temperature_compensation_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [15:0]                            pressure_raw,
	input  logic [15:0]                            temperature_raw,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [16:0]                     temperature_centi,
	output logic signed [21:0]                     pressure_centi
);

	// calibration words
	logic [15:0] cal_word_one_q, cal_word_two_q, cal_word_three_q, cal_word_four_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_word_one_q   <= '0;
			cal_word_two_q   <= '0;
			cal_word_three_q <= '0;
			cal_word_four_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptc_pkg::REG_CAL_ONE:   cal_word_one_q   <= cfg_data;
				ptc_pkg::REG_CAL_TWO:   cal_word_two_q   <= cfg_data;
				ptc_pkg::REG_CAL_THREE: cal_word_three_q <= cfg_data;
				ptc_pkg::REG_CAL_FOUR:  cal_word_four_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ptc_pkg::coef_t coef;
	assign coef = ptc_pkg::unpack_coef(cal_word_one_q, cal_word_two_q,
		cal_word_three_q, cal_word_four_q);

	// coefficient terms, static between calibration writes
	logic [15:0]        ut1;
	logic signed [10:0] t_coef, o_coef, s_coef;
	assign ut1 = {2'b00, coef.c5, 2'b00}
		+ 16'(ptc_pkg::UT1_BASE - 4 * ptc_pkg::C5_BIAS);
	assign t_coef = $signed({3'b000, coef.c6}) + 11'(ptc_pkg::C6_BIAS);
	assign o_coef = $signed({2'b00, coef.c4}) - 11'(ptc_pkg::C4_BIAS);
	assign s_coef = $signed({2'b00, coef.c3}) + 11'(ptc_pkg::C3_BIAS);

	// the whole pipeline moves together unless the output holds a stalled result
	logic advance;
	assign advance  = !(out_valid && out_stall);
	assign in_stall = !advance;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// payload stages
	logic signed [17:0] dt_s1;
	logic [15:0]        d1_s1, d1_s2, d1_s3;
	logic signed [28:0] tprod_s2, oprod_s2, sprod_s2;
	logic signed [17:0] temp_s3, off_s3, sens_s3;
	logic signed [17:0] temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [16:0] temp_s8;
	logic signed [18:0] diff_s4;
	logic signed [17:0] sens_s4;
	logic signed [36:0] xprod_s5;
	logic signed [23:0] x_s6;
	logic signed [35:0] pprod_s7;
	logic signed [21:0] pres_s8;

	// truncating divides: bias negatives by divisor-1 before the arithmetic shift
	logic signed [28:0] tadj, oadj, sadj;
	logic signed [36:0] xadj;
	logic signed [35:0] padj;
	assign tadj = tprod_s2 + (tprod_s2[28] ? 29'((1 << ptc_pkg::TEMP_SHIFT) - 1) : 29'sd0);
	assign oadj = oprod_s2 + (oprod_s2[28] ? 29'((1 << ptc_pkg::OFF_SHIFT) - 1) : 29'sd0);
	assign sadj = sprod_s2 + (sprod_s2[28] ? 29'((1 << ptc_pkg::SENS_SHIFT) - 1) : 29'sd0);
	assign xadj = xprod_s5 + (xprod_s5[36] ? 37'((1 << ptc_pkg::X_SHIFT) - 1) : 37'sd0);
	assign padj = pprod_s7 + (pprod_s7[35] ? 36'((1 << ptc_pkg::P_SHIFT) - 1) : 36'sd0);

	always_ff @(posedge clk) begin
		if (advance) begin
			// s1: dT = D2 - UT1
			dt_s1 <= $signed({2'b00, temperature_raw}) - $signed({2'b00, ut1});
			d1_s1 <= pressure_raw;
			// s2: the three dT products
			tprod_s2 <= 29'(dt_s1) * 29'(t_coef);
			oprod_s2 <= 29'(dt_s1) * 29'(o_coef);
			sprod_s2 <= 29'(dt_s1) * 29'(s_coef);
			d1_s2    <= d1_s1;
			// s3: TEMP, OFF, SENS
			temp_s3 <= 18'(tadj >>> ptc_pkg::TEMP_SHIFT) + 18'(ptc_pkg::TEMP_BASE);
			off_s3  <= 18'(oadj >>> ptc_pkg::OFF_SHIFT) + $signed({5'b0, coef.c2})
				+ 18'(ptc_pkg::OFF_BASE - ptc_pkg::CAL_BIAS);
			sens_s3 <= 18'(sadj >>> ptc_pkg::SENS_SHIFT) + $signed({5'b0, coef.c1})
				+ 18'(ptc_pkg::SENS_BASE - ptc_pkg::CAL_BIAS);
			d1_s3   <= d1_s2;
			// s4: OFF - D1
			diff_s4 <= 19'(off_s3) - $signed({3'b000, d1_s3});
			sens_s4 <= sens_s3;
			temp_s4 <= temp_s3;
			// s5: SENS * (OFF - D1)
			xprod_s5 <= 37'(sens_s4) * 37'(diff_s4);
			temp_s5  <= temp_s4;
			// s6: X
			x_s6    <= 24'(xadj >>> ptc_pkg::X_SHIFT);
			temp_s6 <= temp_s5;
			// s7: X * 1365
			pprod_s7 <= 36'(x_s6) * 36'(ptc_pkg::P_SCALE);
			temp_s7  <= temp_s6;
			// s8: P, fields masked to width
			pres_s8 <= 22'(padj >>> ptc_pkg::P_SHIFT);
			temp_s8 <= 17'(temp_s7);
		end
	end

	assign out_valid         = v_s8;
	assign temperature_centi = temp_s8;
	assign pressure_centi    = pres_s8;

	// checks
	`PTC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v_s1, "accepted item not in stage 1")
	`PTC_ASSERT_NEXT(a_last_to_out, v_s7 && !in_stall, out_valid, "stage 7 item lost on advance")
	`PTC_ASSERT_NEXT(a_stall_freezes, out_valid && out_stall,
		$stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}) && $stable(pres_s8),
		"pipeline moved while output stalled")

endmodule
